// ===== hw/rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the environmental sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef logic signed [31:0] s32_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_TEMP_CAL  = 3'd0,
    REG_PRESS_LO  = 3'd1,
    REG_PRESS_HI  = 3'd2,
    REG_PRESS_P9  = 3'd3,
    REG_HUM_CAL   = 3'd4
  } reg_index_t;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned HumW      = 17;

  localparam s32_t PressOffset = 32'sd64000;
  localparam s32_t HumOffset   = 32'sd76800;
  localparam s32_t HumMax      = 32'sd419430400;

  // calibration words as held in the configuration registers
  typedef struct packed {
    logic [47:0] temp;
    logic [63:0] press_lo;
    logic [63:0] press_hi;
    logic [15:0] press_p9;
    logic [63:0] hum;
  } cal_t;

  // one sample handed from the front part to the back part
  typedef struct packed {
    logic [31:0]     temp;
    logic [HumW-1:0] hum;
    logic [31:0]     numer;
    logic [31:0]     divisor;
  } fitem_t;

endpackage

// ===== hw/rtl/env_sensor_compensation.sv =====
// Throughput: one sample per cycle while the output is not stalled; the 14-stage front
// pipe and the 32-stage divider in the back part each take a new sample every cycle.
// A 4-entry queue between the parts holds up to four samples while the output stalls.
// Reset (rst, synchronous): pipes and queue empty, calibration words zero.
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer temperature, pressure and humidity compensation of raw samples.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,  // temperature_centi[31:0], pressure_pa[63:32], humidity_q10[80:64]
  output logic [0:0]  m_tuser   // pressure_valid[0]
);
  import esc_pkg::*;

  cal_t   cal;
  fitem_t f_item, q_item;
  logic   f_valid, q_full, q_empty, push, pop;
  logic [31:0]     temp_o, press_o;
  logic [HumW-1:0] hum_o;
  logic            pvalid_o;

  // calibration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEMP_CAL: cal.temp     <= cfg_data[47:0];
        REG_PRESS_LO: cal.press_lo <= cfg_data;
        REG_PRESS_HI: cal.press_hi <= cfg_data;
        REG_PRESS_P9: cal.press_p9 <= cfg_data[15:0];
        REG_HUM_CAL:  cal.hum      <= cfg_data;
        default: ;
      endcase
    end
  end

  esc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cal             (cal),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .raw_temperature (s_tdata[19:0]),
    .raw_pressure    (s_tdata[39:20]),
    .raw_humidity    (s_tdata[55:40]),
    .out_valid       (f_valid),
    .out_ready       (!q_full),
    .out_item        (f_item)
  );

  // push when the front's last sample advances
  assign push = f_valid && !q_full;

  esc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (f_item),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .pop_item  (q_item)
  );

  esc_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cal               (cal),
    .in_avail          (!q_empty),
    .in_take           (pop),
    .in_item           (q_item),
    .out_valid         (m_tvalid),
    .out_ready         (m_tready),
    .temperature_centi (temp_o),
    .pressure_pa       (press_o),
    .pressure_valid    (pvalid_o),
    .humidity_q10      (hum_o)
  );

  assign m_tdata = {7'b0, hum_o, press_o, temp_o};
  assign m_tuser = pvalid_o;

endmodule

// ===== hw/rtl/esc_front.sv =====
// ----------------------------------------------------------------------------
// esc_front
// Accepts raw samples and runs the temperature, humidity and pressure-operand
// pipeline; hands finished humidity, temperature, numerator and divisor on.
// ----------------------------------------------------------------------------
module esc_front (
  input  logic            clk,
  input  logic            rst,
  input  esc_pkg::cal_t   cal,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [19:0]     raw_temperature,
  input  logic [19:0]     raw_pressure,
  input  logic [15:0]     raw_humidity,
  output logic            out_valid,
  input  logic            out_ready,
  output esc_pkg::fitem_t out_item
);
  import esc_pkg::*;

  localparam int unsigned Depth = 14;

  logic [Depth-1:0] vld;
  logic             adv;

  s32_t t1, t2, t3, p1, p2, p3, p4, p5, p6, h1, h2, h3, h4, h5, h6;
  s32_t rt32, rp32, rh32;

  // calibration fields
  assign t1 = $signed({16'b0, cal.temp[15:0]});
  assign t2 = $signed(cal.temp[31:16]);
  assign t3 = $signed(cal.temp[47:32]);
  assign p1 = $signed({16'b0, cal.press_lo[15:0]});
  assign p2 = $signed(cal.press_lo[31:16]);
  assign p3 = $signed(cal.press_lo[47:32]);
  assign p4 = $signed(cal.press_lo[63:48]);
  assign p5 = $signed(cal.press_hi[15:0]);
  assign p6 = $signed(cal.press_hi[31:16]);
  assign h1 = $signed({24'b0, cal.hum[7:0]});
  assign h2 = $signed(cal.hum[23:8]);
  assign h3 = $signed({24'b0, cal.hum[31:24]});
  assign h4 = $signed(cal.hum[43:32]);
  assign h5 = $signed(cal.hum[55:44]);
  assign h6 = $signed(cal.hum[63:56]);

  assign rt32 = $signed({12'b0, raw_temperature});

  // stage registers
  s32_t s1_ta, s1_td;
  logic [19:0] s1_rp, s2_rp, s3_rp, s4_rp, s5_rp, s6_rp, s7_rp, s8_rp;
  logic [15:0] s1_rh, s2_rh, s3_rh, s4_rh, s5_rh;
  s32_t s2_tam, s2_tdd;
  s32_t s3_a, s3_tb;
  s32_t s4_fine;
  s32_t s5_temp, s5_pa, s5_x;
  s32_t s6_qq, s6_ap5, s6_p2a, s6_xh6, s6_xh3, s6_u, s6_temp;
  s32_t s7_b1, s7_p3q, s7_w1, s7_ap5, s7_p2a, s7_u, s7_temp;
  s32_t s8_b3, s8_a2, s8_w2, s8_u, s8_temp;
  s32_t s9_a3m, s9_w3, s9_num, s9_u, s9_temp;
  s32_t s10_div, s10_nm, s10_w4, s10_u, s10_temp;
  s32_t s11_hx, s11_div, s11_nm, s11_temp;
  s32_t s12_hm1, s12_hx, s12_div, s12_nm, s12_temp;
  s32_t s13_hm, s13_hx, s13_div, s13_nm, s13_temp;
  logic [HumW-1:0] s14_hum;
  s32_t s14_div, s14_nm, s14_temp;

  // combinational helpers
  s32_t q5, q11, hx14;
  assign q5  = s5_pa >>> 2;
  assign q11 = s11_hx >>> 15;
  assign rp32 = $signed({12'b0, s8_rp});
  assign rh32 = $signed({16'b0, s5_rh});
  assign hx14 = s13_hx - (s13_hm >>> 4);

  // advance the whole pipe unless the last sample is blocked
  assign adv      = !vld[Depth-1] || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // temperature
      s1_ta   <= (rt32 >>> 3) - (t1 <<< 1);
      s1_td   <= (rt32 >>> 4) - t1;
      s1_rp   <= raw_pressure;
      s1_rh   <= raw_humidity;
      s2_tam  <= s1_ta * t2;
      s2_tdd  <= s1_td * s1_td;
      s2_rp   <= s1_rp;
      s2_rh   <= s1_rh;
      s3_a    <= s2_tam >>> 11;
      s3_tb   <= (s2_tdd >>> 12) * t3;
      s3_rp   <= s2_rp;
      s3_rh   <= s2_rh;
      s4_fine <= s3_a + (s3_tb >>> 14);
      s4_rp   <= s3_rp;
      s4_rh   <= s3_rh;
      // fine temperature fan-out
      s5_temp <= ((s4_fine <<< 2) + s4_fine + 32'sd128) >>> 8;
      s5_pa   <= (s4_fine >>> 1) - PressOffset;
      s5_x    <= s4_fine - HumOffset;
      s5_rp   <= s4_rp;
      s5_rh   <= s4_rh;
      // first products
      s6_qq   <= q5 * q5;
      s6_ap5  <= s5_pa * p5;
      s6_p2a  <= p2 * s5_pa;
      s6_xh6  <= s5_x * h6;
      s6_xh3  <= s5_x * h3;
      s6_u    <= ((rh32 <<< 14) - (h4 <<< 20) - (h5 * s5_x) + 32'sd16384) >>> 15;
      s6_temp <= s5_temp;
      s6_rp   <= s5_rp;
      // second products
      s7_b1   <= (s6_qq >>> 11) * p6;
      s7_p3q  <= p3 * (s6_qq >>> 13);
      s7_w1   <= (s6_xh6 >>> 10) * ((s6_xh3 >>> 11) + 32'sd32768);
      s7_ap5  <= s6_ap5;
      s7_p2a  <= s6_p2a;
      s7_u    <= s6_u;
      s7_temp <= s6_temp;
      s7_rp   <= s6_rp;
      // sums
      s8_b3   <= ((s7_b1 + (s7_ap5 <<< 1)) >>> 2) + (p4 <<< 16);
      s8_a2   <= (((s7_p3q >>> 3) + (s7_p2a >>> 1)) >>> 18) + 32'sd32768;
      s8_w2   <= (s7_w1 >>> 10) + 32'sd2097152;
      s8_u    <= s7_u;
      s8_temp <= s7_temp;
      s8_rp   <= s7_rp;
      // divisor product, humidity scale, numerator
      s9_a3m  <= s8_a2 * p1;
      s9_w3   <= s8_w2 * h2;
      s9_num  <= (32'sd1048576 - rp32) - (s8_b3 >>> 12);
      s9_u    <= s8_u;
      s9_temp <= s8_temp;
      s10_div <= s9_a3m >>> 15;
      s10_nm  <= s9_num * 32'sd3125;
      s10_w4  <= (s9_w3 + 32'sd8192) >>> 14;
      s10_u   <= s9_u;
      s10_temp <= s9_temp;
      // humidity tail
      s11_hx   <= s10_u * s10_w4;
      s11_div  <= s10_div;
      s11_nm   <= s10_nm;
      s11_temp <= s10_temp;
      s12_hm1  <= q11 * q11;
      s12_hx   <= s11_hx;
      s12_div  <= s11_div;
      s12_nm   <= s11_nm;
      s12_temp <= s11_temp;
      s13_hm   <= (s12_hm1 >>> 7) * h1;
      s13_hx   <= s12_hx;
      s13_div  <= s12_div;
      s13_nm   <= s12_nm;
      s13_temp <= s12_temp;
      // clamp to 0..100 %RH
      if (hx14 < 0) begin
        s14_hum <= '0;
      end else if (hx14 > HumMax) begin
        s14_hum <= HumW'(HumMax >>> 12);
      end else begin
        s14_hum <= HumW'(hx14 >>> 12);
      end
      s14_div  <= s13_div;
      s14_nm   <= s13_nm;
      s14_temp <= s13_temp;
    end
  end

  assign out_valid        = vld[Depth-1];
  assign out_item.temp    = s14_temp;
  assign out_item.hum     = s14_hum;
  assign out_item.numer   = s14_nm;
  assign out_item.divisor = s14_div;

endmodule

// ===== hw/rtl/esc_queue.sv =====
// ----------------------------------------------------------------------------
// esc_queue
// Short FIFO between the front and back parts so each side stalls on its own.
// ----------------------------------------------------------------------------
module esc_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  esc_pkg::fitem_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output esc_pkg::fitem_t pop_item
);
  import esc_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  fitem_t          mem [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [PtrW:0]   count;

  assign full     = (count == (PtrW+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // store beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/esc_back.sv =====
// ----------------------------------------------------------------------------
// esc_back
// Pipelined unsigned divide for pressure, then the second-order pressure
// correction; last stage is the output register.
// ----------------------------------------------------------------------------
module esc_back (
  input  logic            clk,
  input  logic            rst,
  input  esc_pkg::cal_t   cal,
  input  logic            in_avail,
  output logic            in_take,
  input  esc_pkg::fitem_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [31:0]     temperature_centi,
  output logic [31:0]     pressure_pa,
  output logic            pressure_valid,
  output logic [esc_pkg::HumW-1:0] humidity_q10
);
  import esc_pkg::*;

  localparam int unsigned Bits  = 32;
  localparam int unsigned Depth = Bits + 5;

  typedef struct packed {
    logic [31:0]     rem;
    logic [31:0]     dq;
    logic [31:0]     divisor;
    logic            dbl;
    logic            zero;
    logic [31:0]     temp;
    logic [HumW-1:0] hum;
  } dstage_t;

  dstage_t         ds [Bits+1];
  logic [Depth-1:0] vld;
  logic            adv;

  s32_t p7, p8, p9;
  assign p7 = $signed(cal.press_hi[47:32]);
  assign p8 = $signed(cal.press_hi[63:48]);
  assign p9 = $signed(cal.press_p9);

  assign adv     = !vld[Depth-1] || out_ready;
  assign in_take = adv && in_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[Depth-2:0], in_take};
    end
  end

  // load the divider: double before dividing while the numerator allows it
  always_ff @(posedge clk) begin
    if (adv) begin
      ds[0].rem     <= '0;
      ds[0].dbl     <= in_item.numer[31];
      ds[0].dq      <= in_item.numer[31] ? in_item.numer : {in_item.numer[30:0], 1'b0};
      ds[0].divisor <= in_item.divisor;
      ds[0].zero    <= (in_item.divisor == '0);
      ds[0].temp    <= in_item.temp;
      ds[0].hum     <= in_item.hum;
    end
  end

  // one quotient bit per stage
  for (genvar k = 1; k <= Bits; k++) begin : g_div
    logic [32:0] trial, diff;
    assign trial = {ds[k-1].rem, ds[k-1].dq[31]};
    assign diff  = trial - {1'b0, ds[k-1].divisor};
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k].rem     <= diff[32] ? trial[31:0] : diff[31:0];
        ds[k].dq      <= {ds[k-1].dq[30:0], ~diff[32]};
        ds[k].divisor <= ds[k-1].divisor;
        ds[k].dbl     <= ds[k-1].dbl;
        ds[k].zero    <= ds[k-1].zero;
        ds[k].temp    <= ds[k-1].temp;
        ds[k].hum     <= ds[k-1].hum;
      end
    end
  end

  logic [31:0] quot;
  assign quot = ds[Bits].dbl ? {ds[Bits].dq[30:0], 1'b0} : ds[Bits].dq;

  logic [31:0]     m1_p, m1_sq, m2_p, m2_sq;
  s32_t            m1_pe, m2_pe, m3_c1, m3_pe;
  logic [31:0]     m3_p;
  logic            m1_zero, m2_zero, m3_zero;
  logic [31:0]     m1_temp, m2_temp, m3_temp, o_temp;
  logic [HumW-1:0] m1_hum, m2_hum, m3_hum, o_hum;
  logic [31:0]     o_press;
  logic            o_pvalid;
  s32_t            corr;

  assign corr = ((m3_c1 >>> 12) + (m3_pe >>> 13) + p7) >>> 4;

  // correction terms
  always_ff @(posedge clk) begin
    if (adv) begin
      m1_p    <= quot;
      m1_sq   <= {3'b0, quot[31:3]} * {3'b0, quot[31:3]};
      m1_pe   <= $signed({2'b0, quot[31:2]}) * p8;
      m1_zero <= ds[Bits].zero;
      m1_temp <= ds[Bits].temp;
      m1_hum  <= ds[Bits].hum;
      m2_p    <= m1_p;
      m2_sq   <= {13'b0, m1_sq[31:13]};
      m2_pe   <= m1_pe;
      m2_zero <= m1_zero;
      m2_temp <= m1_temp;
      m2_hum  <= m1_hum;
      m3_c1   <= p9 * $signed(m2_sq);
      m3_pe   <= m2_pe;
      m3_p    <= m2_p;
      m3_zero <= m2_zero;
      m3_temp <= m2_temp;
      m3_hum  <= m2_hum;
      // output register
      o_press  <= m3_zero ? '0 : (m3_p + corr);
      o_pvalid <= !m3_zero;
      o_temp   <= m3_temp;
      o_hum    <= m3_hum;
    end
  end

  assign out_valid         = vld[Depth-1];
  assign temperature_centi = o_temp;
  assign pressure_pa       = o_press;
  assign pressure_valid    = o_pvalid;
  assign humidity_q10      = o_hum;

endmodule

// ===== hw/rtl/esc_checker.sv =====
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks for env_sensor_compensation, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [87:0] m_tdata,
  input logic [0:0]  m_tuser
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // pressure forced to zero when flagged invalid
  a_press_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[63:32] == 32'd0)
    else $error("invalid pressure not zero");

  // humidity stays clamped
  a_hum_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[80:64] <= 17'd102400 && m_tdata[87:81] == 7'd0)
    else $error("humidity out of range");

  // no result directly after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (.*);
